FILE: design/vumlb_pkg.sv
// Types, constants and the log table shared by the VU meter LED bar blocks.
// No dependencies.
package vumlb_pkg;

    localparam int LEVEL_BITS = 16;
    localparam logic [10:0] OCTAVE_ATT = 11'd1541;
    localparam logic [15:0] PEAK_DECAY = 16'd1966;
    localparam logic [23:0] RECIP100 = 24'd10737419;   // ceil(2^30/100)
    localparam logic [25:0] RECIP10 = 26'd53687092;    // ceil(2^29/10)
    localparam logic [4:0] BAR_STEPS = 5'd17;
    localparam logic [4:0] COLOR_STEPS = 5'd8;

    typedef enum logic [2:0] {
        REG_SMOOTHING = 3'd0,
        REG_GAIN = 3'd1,
        REG_FLOOR = 3'd2,
        REG_PEAK = 3'd3,
        REG_SPLIT = 3'd4,
        REG_BRIGHT = 3'd5,
        REG_LEDS = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_MUL,
        F_DIV100,
        F_GAIN,
        F_DIV10,
        F_LOG,
        F_ATT,
        F_BAR,
        F_BARDIV,
        F_PEAK,
        F_LIT,
        F_RDIV,
        F_RWAIT,
        F_PUSH
    } front_state_t;

    typedef struct packed {
        logic [6:0] smoothing_pct;
        logic [9:0] gain_x10;
        logic signed [7:0] floor_db;
        logic peak_detect;
        logic stereo_split;
        logic [7:0] max_brightness;
        logic [6:0] led_count;
    } cfg_t;

    typedef struct packed {
        logic [1:0][6:0] lit;
        logic [1:0][6:0] pk;
        logic [1:0][7:0] quo;
        logic [1:0][5:0] rmd;
    } frame_t;

    typedef struct packed {
        logic start;
        logic [4:0] steps;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [16:0] quotient;
        logic [15:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic [5:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic last_led;
    } led_t;

    function automatic logic [10:0] log_tab(input logic [5:0] idx);
        logic [10:0] v;
        unique case (idx)
            6'd0: v = 11'd0;     6'd1: v = 11'd68;    6'd2: v = 11'd135;
            6'd3: v = 11'd199;   6'd4: v = 11'd262;   6'd5: v = 11'd323;
            6'd6: v = 11'd382;   6'd7: v = 11'd440;   6'd8: v = 11'd496;
            6'd9: v = 11'd551;   6'd10: v = 11'd605;  6'd11: v = 11'd657;
            6'd12: v = 11'd708;  6'd13: v = 11'd758;  6'd14: v = 11'd807;
            6'd15: v = 11'd855;  6'd16: v = 11'd902;  6'd17: v = 11'd947;
            6'd18: v = 11'd992;  6'd19: v = 11'd1036; 6'd20: v = 11'd1080;
            6'd21: v = 11'd1122; 6'd22: v = 11'd1163; 6'd23: v = 11'd1204;
            6'd24: v = 11'd1244; 6'd25: v = 11'd1284; 6'd26: v = 11'd1322;
            6'd27: v = 11'd1360; 6'd28: v = 11'd1398; 6'd29: v = 11'd1435;
            6'd30: v = 11'd1471; 6'd31: v = 11'd1506; 6'd32: v = 11'd1541;
            default: v = 11'd0;
        endcase
        return v;
    endfunction

    function automatic logic [6:0] clip_leds(input logic [6:0] cnt, input logic [6:0] maxv);
        return (cnt > maxv) ? maxv : cnt;
    endfunction

endpackage

FILE: design/vumlb_fifo.sv
// Small register queue, power-of-two depth, used between front and back and at the output.
// Depends on nothing.
module vumlb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic do_wr, do_rd;

    assign full = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= AW'(wr_ptr_reg + 1'b1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= AW'(rd_ptr_reg + 1'b1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= CW'(count_reg + 1'b1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= CW'(count_reg - 1'b1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: design/vumlb_div.sv
// Restoring divider, one quotient bit per cycle, for the bar position and color steps.
// Depends on vumlb_pkg.
module vumlb_div
    import vumlb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic busy_reg, done_reg;
    logic [4:0] cnt_reg;
    logic [15:0] rem_reg, div_reg;
    logic [31:0] sh_reg;
    logic [16:0] q_reg;
    logic [16:0] trial;
    logic ge;

    assign trial = {rem_reg, sh_reg[31]};
    assign ge = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= 5'(cnt_reg - 1'b1);
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            rem_reg <= 16'(req.dividend >> req.steps);
            sh_reg <= req.dividend << (6'd32 - {1'b0, req.steps});
            div_reg <= req.divisor;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 16'(trial - {1'b0, div_reg}) : trial[15:0];
            sh_reg <= {sh_reg[30:0], 1'b0};
            q_reg <= {q_reg[15:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = q_reg;
    assign rsp.remainder = rem_reg;

    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> !done_reg)
        else $error("divider done while still busy");

endmodule

FILE: design/vumlb_front.sv
// Front part: smoothing, gain, dB bar position, peak hold and per-section render setup.
// Depends on vumlb_pkg; uses the shared divider through div_req/div_rsp.
module vumlb_front
    import vumlb_pkg::*;
#(
    parameter int MAX_LEDS = 64,
    parameter int HOLD_TICKS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        push,
    input  logic        has_new_level,
    input  logic [15:0] left_level,
    input  logic [15:0] right_level,
    output logic        ready,
    output div_req_t    div_req,
    input  div_rsp_t    div_rsp,
    output frame_t      frame,
    output logic        frame_push,
    input  logic        frame_full
);

    front_state_t state_reg, state_next;
    logic ch_reg;
    logic [15:0] x_reg [2];
    logic [15:0] sm_reg [2];
    logic [15:0] pk_reg [2];
    logic [4:0] hold_reg [2];
    logic [15:0] bar_reg [2];
    logic [22:0] pa_reg, pb_reg;
    logic [25:0] acc_reg;
    logic [15:0] g_reg;
    logic gz_reg;
    logic [10:0] tb_reg;
    logic [6:0] td_reg;
    logic [9:0] rm_reg;
    logic [3:0] p_reg;
    logic [14:0] att_reg;
    frame_t frame_reg;

    logic [6:0] p_sat;
    logic [22:0] v100;
    logic [46:0] prod100;
    logic [51:0] prod10;
    logic [22:0] q10;
    logic [3:0] lead;
    logic [15:0] mn;
    logic [10:0] tcur, tnxt;
    logic [16:0] tint;
    logic [10:0] tval;
    logic [4:0] oct;
    logic [19:0] octatt;
    logic [7:0] neg_floor;
    logic [15:0] fa;
    logic bar_zero;
    logic [31:0] bar_dividend;
    logic [6:0] n, half, sec_c, bc;
    logic [15:0] sec_lvl, sec_pk, mono_lvl, mono_pk;
    logic [23:0] litp, pkp;
    logic [7:0] lit_raw, pk_raw;
    logic [6:0] lit_val, pk_val;

    assign p_sat = (cfg.smoothing_pct > 7'd100) ? 7'd100 : cfg.smoothing_pct;
    assign v100 = 23'(pa_reg + pb_reg + 23'd50);
    assign prod100 = 47'(v100) * 47'(RECIP100);
    assign prod10 = 52'(acc_reg) * 52'(RECIP10);
    assign q10 = prod10[51:29];

    always_comb
    begin
        lead = '0;
        for (int k = 0; k < 16; k++)
        begin
            if (g_reg[k])
            begin
                lead = 4'(k);
            end
        end
    end

    assign mn = g_reg << (4'd15 - lead);
    assign tcur = log_tab({1'b0, mn[14:10]});
    assign tnxt = log_tab(6'({1'b0, mn[14:10]} + 6'd1));
    assign tint = 17'(td_reg) * 17'(rm_reg);
    assign tval = 11'(tb_reg + 11'(tint[16:10]));
    assign oct = 5'(5'd16 - {1'b0, p_reg});
    assign octatt = 20'(oct) * 20'(OCTAVE_ATT);

    assign neg_floor = 8'(~cfg.floor_db + 8'sd1);
    assign fa = {neg_floor, 8'd0};
    assign bar_zero = gz_reg || !cfg.floor_db[7] || ({1'b0, att_reg} >= fa);
    assign bar_dividend = {16'(fa - {1'b0, att_reg}), 16'd0} + 32'(fa[15:1]);

    assign n = clip_leds(cfg.led_count, 7'(MAX_LEDS));
    assign half = n >> 1;
    assign mono_lvl = 16'((17'(bar_reg[0]) + 17'(bar_reg[1])) >> 1);
    assign mono_pk = 16'((17'(pk_reg[0]) + 17'(pk_reg[1])) >> 1);
    assign sec_c = ch_reg ? (cfg.stereo_split ? 7'(n - half) : 7'd0)
                          : (cfg.stereo_split ? half : n);
    assign sec_lvl = ch_reg ? bar_reg[1] : (cfg.stereo_split ? bar_reg[0] : mono_lvl);
    assign sec_pk = ch_reg ? pk_reg[1] : (cfg.stereo_split ? pk_reg[0] : mono_pk);
    assign bc = (cfg.peak_detect && sec_c > 7'd1) ? 7'(sec_c - 1'b1) : sec_c;
    assign litp = 24'(sec_lvl) * 24'(bc) + 24'd32768;
    assign pkp = 24'(sec_pk) * 24'(bc) + 24'd32768;
    assign lit_raw = litp[23:16];
    assign pk_raw = pkp[23:16];
    assign lit_val = (lit_raw > {1'b0, bc}) ? bc : lit_raw[6:0];
    assign pk_val = (pk_raw >= {1'b0, sec_c}) ? 7'(sec_c - 1'b1) : pk_raw[6:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:   if (push) state_next = F_MUL;
            F_MUL:    state_next = F_DIV100;
            F_DIV100: state_next = F_GAIN;
            F_GAIN:   state_next = F_DIV10;
            F_DIV10:  state_next = F_LOG;
            F_LOG:    state_next = F_ATT;
            F_ATT:    state_next = F_BAR;
            F_BAR:    state_next = bar_zero ? F_PEAK : F_BARDIV;
            F_BARDIV: if (div_rsp.done) state_next = F_PEAK;
            F_PEAK:
            begin
                if (!ch_reg)
                begin
                    state_next = F_MUL;
                end
                else
                begin
                    state_next = (n == 7'd0) ? F_IDLE : F_LIT;
                end
            end
            F_LIT:    state_next = F_RDIV;
            F_RDIV:
            begin
                if (sec_c > 7'd1)
                begin
                    state_next = F_RWAIT;
                end
                else
                begin
                    state_next = ch_reg ? F_PUSH : F_LIT;
                end
            end
            F_RWAIT:  if (div_rsp.done) state_next = ch_reg ? F_PUSH : F_LIT;
            F_PUSH:   if (!frame_full) state_next = F_IDLE;
            default:  state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        ready = (state_reg == F_IDLE);
        frame_push = (state_reg == F_PUSH) && !frame_full;
        div_req.start = ((state_reg == F_BAR) && !bar_zero)
                     || ((state_reg == F_RDIV) && (sec_c > 7'd1));
        div_req.steps = (state_reg == F_BAR) ? BAR_STEPS : COLOR_STEPS;
        div_req.dividend = (state_reg == F_BAR) ? bar_dividend : 32'd255;
        div_req.divisor = (state_reg == F_BAR) ? fa : 16'(7'(sec_c - 1'b1));
    end

    assign frame = frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            ch_reg <= 1'b0;
            sm_reg[0] <= '0;
            sm_reg[1] <= '0;
            pk_reg[0] <= '0;
            pk_reg[1] <= '0;
            hold_reg[0] <= '0;
            hold_reg[1] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                F_IDLE:   ch_reg <= 1'b0;
                F_DIV100: sm_reg[ch_reg] <= prod100[45:30];
                F_PEAK:
                begin
                    if (bar_reg[ch_reg] >= pk_reg[ch_reg])
                    begin
                        pk_reg[ch_reg] <= bar_reg[ch_reg];
                        hold_reg[ch_reg] <= 5'(HOLD_TICKS);
                    end
                    else if (hold_reg[ch_reg] != 5'd0)
                    begin
                        hold_reg[ch_reg] <= 5'(hold_reg[ch_reg] - 1'b1);
                    end
                    else
                    begin
                        pk_reg[ch_reg] <= (pk_reg[ch_reg] > PEAK_DECAY)
                                        ? 16'(pk_reg[ch_reg] - PEAK_DECAY) : 16'd0;
                    end
                    ch_reg <= !ch_reg;
                end
                F_RDIV:   if (sec_c <= 7'd1) ch_reg <= !ch_reg;
                F_RWAIT:  if (div_rsp.done) ch_reg <= !ch_reg;
                default:  ch_reg <= ch_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                x_reg[0] <= has_new_level ? left_level : sm_reg[0];
                x_reg[1] <= has_new_level ? right_level : sm_reg[1];
            end
            F_MUL:
            begin
                pa_reg <= 23'(sm_reg[ch_reg]) * 23'(p_sat);
                pb_reg <= 23'(x_reg[ch_reg]) * 23'(7'(7'd100 - p_sat));
            end
            F_GAIN:   acc_reg <= 26'(sm_reg[ch_reg]) * 26'(cfg.gain_x10) + 26'd5;
            F_DIV10:  g_reg <= (q10[22:16] != '0) ? 16'hFFFF : q10[15:0];
            F_LOG:
            begin
                gz_reg <= (g_reg == '0);
                p_reg <= lead;
                tb_reg <= tcur;
                td_reg <= 7'(tnxt - tcur);
                rm_reg <= mn[9:0];
            end
            F_ATT:    att_reg <= 15'(octatt - 20'(tval));
            F_BAR:    if (bar_zero) bar_reg[ch_reg] <= '0;
            F_BARDIV:
            begin
                if (div_rsp.done)
                begin
                    bar_reg[ch_reg] <= div_rsp.quotient[16] ? 16'hFFFF
                                                            : div_rsp.quotient[15:0];
                end
            end
            F_LIT:
            begin
                frame_reg.lit[ch_reg] <= lit_val;
                frame_reg.pk[ch_reg] <= pk_val;
            end
            F_RDIV:
            begin
                if (sec_c <= 7'd1)
                begin
                    frame_reg.quo[ch_reg] <= '0;
                    frame_reg.rmd[ch_reg] <= '0;
                end
            end
            F_RWAIT:
            begin
                if (div_rsp.done)
                begin
                    frame_reg.quo[ch_reg] <= div_rsp.quotient[7:0];
                    frame_reg.rmd[ch_reg] <= div_rsp.remainder[5:0];
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == F_BARDIV || state_reg == F_RWAIT))
        else $error("divider result arrived with nobody waiting");

endmodule

FILE: design/vumlb_back.sv
// Back part: walks the LEDs of one frame, builds the colors and applies the brightness cap.
// Depends on vumlb_pkg.
module vumlb_back
    import vumlb_pkg::*;
#(
    parameter int MAX_LEDS = 64
) (
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  frame_t frame,
    input  logic   frame_valid,
    output logic   frame_pop,
    output led_t   word,
    output logic   word_wr,
    input  logic   out_full
);

    logic busy_reg, sec_reg;
    frame_t cur_reg;
    logic [6:0] i_reg;
    logic [5:0] j_reg;
    logic [7:0] q_reg;
    logic [5:0] r_reg;

    logic [6:0] n, half, c, d, lit, pk;
    logic [7:0] quo;
    logic [5:0] rmd;
    logic [6:0] rem2;
    logic is_pk, is_lit, last, to_upper;
    logic [7:0] r_raw, g_raw, b_raw;

    function automatic logic [7:0] cap(input logic [7:0] v, input logic [7:0] mb);
        logic [15:0] p;
        logic [16:0] s;
        p = 16'(v) * 16'(mb);
        s = 17'(p) + 17'(p[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    assign n = clip_leds(cfg.led_count, 7'(MAX_LEDS));
    assign half = n >> 1;
    assign c = sec_reg ? 7'(n - half) : (cfg.stereo_split ? half : n);
    assign d = 7'(c - 1'b1);
    assign lit = cur_reg.lit[sec_reg];
    assign pk = cur_reg.pk[sec_reg];
    assign quo = cur_reg.quo[sec_reg];
    assign rmd = cur_reg.rmd[sec_reg];
    assign rem2 = 7'(r_reg) + 7'(rmd);

    assign is_pk = cfg.peak_detect && ({1'b0, j_reg} == pk);
    assign is_lit = ({1'b0, j_reg} < lit);
    assign last = (7'(i_reg + 1'b1) == n);
    assign to_upper = cfg.stereo_split && (7'(i_reg + 1'b1) == half);

    always_comb
    begin
        r_raw = 8'd0;
        g_raw = 8'd0;
        b_raw = 8'd0;
        priority if (is_pk)
        begin
            b_raw = 8'd255;
        end
        else if (is_lit)
        begin
            if (c > 7'd1)
            begin
                r_raw = q_reg;
                g_raw = 8'(8'd255 - q_reg - {7'd0, (r_reg != '0)});
            end
            else
            begin
                g_raw = 8'd255;
            end
        end
    end

    assign frame_pop = !busy_reg && frame_valid;
    assign word_wr = busy_reg && !out_full;
    assign word.led_index = i_reg[5:0];
    assign word.red = cap(r_raw, cfg.max_brightness);
    assign word.green = cap(g_raw, cfg.max_brightness);
    assign word.blue = cap(b_raw, cfg.max_brightness);
    assign word.last_led = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (frame_pop)
        begin
            busy_reg <= 1'b1;
        end
        else if (word_wr && last)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_pop)
        begin
            cur_reg <= frame;
            i_reg <= '0;
            j_reg <= '0;
            q_reg <= '0;
            r_reg <= '0;
            sec_reg <= cfg.stereo_split && (half == 7'd0);
        end
        else if (word_wr)
        begin
            i_reg <= 7'(i_reg + 1'b1);
            if (to_upper)
            begin
                sec_reg <= 1'b1;
                j_reg <= '0;
                q_reg <= '0;
                r_reg <= '0;
            end
            else
            begin
                j_reg <= 6'(j_reg + 1'b1);
                if (rem2 >= d)
                begin
                    r_reg <= 6'(rem2 - d);
                    q_reg <= 8'(q_reg + quo + 1'b1);
                end
                else
                begin
                    r_reg <= rem2[5:0];
                    q_reg <= 8'(q_reg + quo);
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> (i_reg < n))
        else $error("LED walk ran past the strip");

    assert property (@(posedge clk) disable iff (!rst_n) (word_wr && last) |=> !busy_reg)
        else $error("walk kept going after the last LED");

endmodule

FILE: design/vu_meter_led_bar_peak_hold_unit.sv
// VU meter with peak hold: one frame tick in, one RGB word per LED out.
// Usage:
//  Input queue: push a frame tick (has_new_level, left_level, right_level) when full is
//  low. Result queue: while empty is low the oldest LED word is on led_index, red, green,
//  blue and last_led; pop takes it. last_led marks the final word of a frame.
//  Config: wr_en/wr_index/wr_data writes one register at once; write only while idle.
// Flow:
//  Per tick the front part runs, per channel, the level math (F_MUL to F_BAR), the
//  shared bit-serial divider for the bar position (skipped for an empty bar) and the
//  peak step; then per strip section F_LIT and F_RDIV plus the divider for the color
//  ramp, and F_PUSH to hand the frame over. full stays high until the front is idle
//  again, so no new tick is taken while one is in work. The back part then emits one
//  LED word per cycle while the result queue has room, min(led_count, MAX_LEDS) words
//  per frame, overlapped with the front working on the next tick through a two-entry
//  frame queue.
// Reset: registers return to their defaults, levels, peaks and hold counters clear.
// Stalls: a held-off pop fills the 4-word result queue, then the back part waits,
//  then the frame queue fills, then the front part waits and full stays high.
// Depends on vumlb_pkg, vumlb_front, vumlb_div, vumlb_back, vumlb_fifo.
module vu_meter_led_bar_peak_hold_unit
    import vumlb_pkg::*;
#(
    parameter int MAX_LEDS = 64,
    parameter int HOLD_TICKS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        has_new_level,
    input  logic [15:0] left_level,
    input  logic [15:0] right_level,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  led_index,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        last_led,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [9:0]  wr_data
);

    cfg_t cfg_reg;
    logic front_ready;
    div_req_t div_req;
    div_rsp_t div_rsp;
    frame_t front_frame, back_frame;
    logic frame_push, frame_full, frame_empty, frame_pop;
    logic [$bits(frame_t)-1:0] frame_rdata;
    led_t word, out_word;
    logic word_wr, out_full;
    logic [$bits(led_t)-1:0] out_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_pct <= 7'd50;
            cfg_reg.gain_x10 <= 10'd10;
            cfg_reg.floor_db <= -8'sd60;
            cfg_reg.peak_detect <= 1'b1;
            cfg_reg.stereo_split <= 1'b0;
            cfg_reg.max_brightness <= 8'd255;
            cfg_reg.led_count <= 7'd64;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_SMOOTHING: cfg_reg.smoothing_pct <= wr_data[6:0];
                REG_GAIN:      cfg_reg.gain_x10 <= wr_data;
                REG_FLOOR:     cfg_reg.floor_db <= wr_data[7:0];
                REG_PEAK:      cfg_reg.peak_detect <= wr_data[0];
                REG_SPLIT:     cfg_reg.stereo_split <= wr_data[0];
                REG_BRIGHT:    cfg_reg.max_brightness <= wr_data[7:0];
                REG_LEDS:      cfg_reg.led_count <= wr_data[6:0];
                default: ;
            endcase
        end
    end

    assign full = !front_ready;

    vumlb_front #(
        .MAX_LEDS(MAX_LEDS),
        .HOLD_TICKS(HOLD_TICKS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .push(push),
        .has_new_level(has_new_level),
        .left_level(left_level),
        .right_level(right_level),
        .ready(front_ready),
        .div_req(div_req),
        .div_rsp(div_rsp),
        .frame(front_frame),
        .frame_push(frame_push),
        .frame_full(frame_full)
    );

    vumlb_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .req(div_req),
        .rsp(div_rsp)
    );

    vumlb_fifo #(
        .WIDTH($bits(frame_t)),
        .DEPTH(2)
    ) u_frame_q (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(frame_push),
        .wdata(front_frame),
        .full(frame_full),
        .rd_en(frame_pop),
        .rdata(frame_rdata),
        .empty(frame_empty)
    );

    assign back_frame = frame_t'(frame_rdata);

    vumlb_back #(
        .MAX_LEDS(MAX_LEDS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .frame(back_frame),
        .frame_valid(!frame_empty),
        .frame_pop(frame_pop),
        .word(word),
        .word_wr(word_wr),
        .out_full(out_full)
    );

    vumlb_fifo #(
        .WIDTH($bits(led_t)),
        .DEPTH(4)
    ) u_out_q (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(word_wr),
        .wdata(word),
        .full(out_full),
        .rd_en(pop),
        .rdata(out_rdata),
        .empty(empty)
    );

    assign out_word = led_t'(out_rdata);
    assign led_index = out_word.led_index;
    assign red = out_word.red;
    assign green = out_word.green;
    assign blue = out_word.blue;
    assign last_led = out_word.last_led;

endmodule
